[hdl/aea_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aea_pkg
// Shared types, codes and helpers of the aligned extent allocator.
// ----------------------------------------------------------------------------
package aea_pkg;

  localparam int ADDR_W      = 49;
  localparam int XW          = ADDR_W + 2;   // room for rounding and end sums
  localparam int ENT_W       = 2 * ADDR_W;
  localparam int MAX_EXTENTS = 64;

  localparam logic [ADDR_W-1:0] SIZE_LIMIT = ADDR_W'(1) << 48;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] REG_ALIGN = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_SIZE  = 2'd2;

  localparam logic [4:0] ALIGN_RESET = 5'd12;

  typedef struct packed {
    logic [4:0]        align_log2;
    logic [ADDR_W-1:0] pool_base;
    logic [ADDR_W-1:0] pool_size;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } extent_t;

  function automatic logic [XW-1:0] round_up(input logic [XW-1:0] v,
                                             input logic [4:0] al);
    logic [XW-1:0] m;
    m = (XW'(1) << al) - XW'(1);
    return (v + m) & ~m;
  endfunction

endpackage

[hdl/aea_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aea_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module aea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/aea_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aea_cfg
// Configuration register file: alignment, pool base and pool size.
// ----------------------------------------------------------------------------
module aea_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [aea_pkg::ADDR_W-1:0] cfg_data,
  output aea_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.align_log2 <= aea_pkg::ALIGN_RESET;
      cfg.pool_base  <= '0;
      cfg.pool_size  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aea_pkg::REG_ALIGN: cfg.align_log2 <= cfg_data[4:0];
        aea_pkg::REG_BASE:  cfg.pool_base  <= cfg_data;
        aea_pkg::REG_SIZE:  cfg.pool_size  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/aligned_extent_allocator.sv]
`timescale 1ns / 1ps
// One request at a time; the next is taken once the result is in the output
// register. Rate is set by the single read port of the extent RAM.
// Reset clears count, free sum, pool base and size, sets align_log2 to 12
// and sets region id to 1; RAM not cleared.
// ----------------------------------------------------------------------------
// aligned_extent_allocator
// First-fit aligned allocator over a sorted free-extent list with coalescing.
// ----------------------------------------------------------------------------
module aligned_extent_allocator #(
  parameter int MAX_EXTENTS = aea_pkg::MAX_EXTENTS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [aea_pkg::ADDR_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [1:0]                 operation,
  input  logic [aea_pkg::ADDR_W-1:0] request_size,
  input  logic [aea_pkg::ADDR_W-1:0] free_offset,
  input  logic [aea_pkg::ADDR_W-1:0] free_length,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [1:0]                 status,
  output logic [aea_pkg::ADDR_W-1:0] block_offset,
  output logic [aea_pkg::ADDR_W-1:0] block_length,
  output logic [63:0]                region_id,
  output logic [aea_pkg::ADDR_W-1:0] free_total
);

  localparam int AW = aea_pkg::ADDR_W;
  localparam int XW = aea_pkg::XW;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_PREP2, S_RD_REQ, S_RD_LOAD, S_CHK, S_FIT, S_DEC,
    S_FIN, S_FIN2, S_SH_RD, S_SH_WR, S_WR1, S_WR2, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_ALLOC, PH_FPOS, PH_FABS} phase_t;

  aea_pkg::cfg_t    cfg;
  aea_pkg::extent_t ext_rd;

  state_t  state;
  phase_t  phase;

  logic [1:0]    op_q;
  logic [AW-1:0] req_q, off_q, len_q, fend_q, asz_q;
  logic [CW-1:0] count, j;
  logic [63:0]   next_region;
  logic [AW-1:0] free_sum;

  logic [AW-1:0] cur_s, cur_z;
  logic [XW-1:0] cur_e, cur_a, cur_end;

  logic          has_prev, has_next;
  logic [AW-1:0] prev_s, prev_e, prev_z, next_s, next_e, next_z;
  logic [IW-1:0] p_q;
  logic [AW-1:0] ms, me, removed, len_m;
  logic [CW-1:0] k_q;

  logic          sh_up;
  logic [CW-1:0] sh_src, sh_stop, sh_k;

  logic          w1_en, w2_en;
  logic [IW-1:0] w1_addr, w2_addr;
  logic [aea_pkg::ENT_W-1:0] w1_data, w2_data;

  logic [1:0]    st_q;
  logic [AW-1:0] boff_q, blen_q;
  logic [63:0]   rid_q;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr, ram_raddr;
  logic [aea_pkg::ENT_W-1:0] ram_wdata, ram_rdata;

  logic [XW-1:0] ru_req, ru_s;
  logic          fit_front, fit_back;
  logic [AW-1:0] init_len, free_cut;
  logic [CW-1:0] sh_dest;
  logic [CW-1:0] fin_lo;

  aea_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aea_ram #(
    .WIDTH (aea_pkg::ENT_W),
    .DEPTH (MAX_EXTENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ext_rd    = aea_pkg::extent_t'(ram_rdata);
  assign ru_req    = aea_pkg::round_up({2'b00, req_q}, cfg.align_log2);
  assign ru_s      = aea_pkg::round_up({2'b00, ext_rd.start}, cfg.align_log2);
  assign fit_front = cur_a > {2'b00, cur_s};
  assign fit_back  = cur_end < cur_e;
  // the end cut against the top of the address space: limit is ~base
  assign init_len  = (cfg.pool_size > ~cfg.pool_base) ? ~cfg.pool_base : cfg.pool_size;
  assign free_cut  = (len_q > ~off_q) ? ~off_q : len_q;
  assign sh_dest   = sh_up ? (sh_src + CW'(1)) : (sh_src - sh_k);
  assign fin_lo    = CW'(p_q) + CW'(1) + k_q;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w1_addr;
    ram_wdata = w1_data;
    ram_raddr = j[IW-1:0];
    unique case (state)
      S_SH_RD: ram_raddr = sh_src[IW-1:0];
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_dest[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_WR1: ram_we = w1_en;
      S_WR2: begin
        ram_we    = w2_en;
        ram_waddr = w2_addr;
        ram_wdata = w2_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_ALLOC;
      count       <= '0;
      next_region <= 64'd1;
      free_sum    <= '0;
      res_valid   <= 1'b0;
      w1_en       <= 1'b0;
      w2_en       <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q   <= operation;
            req_q  <= request_size;
            off_q  <= free_offset;
            len_q  <= free_length;
            boff_q <= '0;
            blen_q <= '0;
            rid_q  <= '0;
            st_q   <= aea_pkg::ST_OK;
            w1_en  <= 1'b0;
            w2_en  <= 1'b0;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          j <= '0;
          unique case (op_q)
            aea_pkg::OP_INIT: begin
              w1_en       <= (init_len != '0);
              w1_addr     <= '0;
              w1_data     <= {cfg.pool_base, init_len};
              count       <= (init_len != '0) ? CW'(1) : CW'(0);
              next_region <= 64'd1;
              free_sum    <= init_len;
              state       <= S_WR1;
            end
            aea_pkg::OP_ALLOC: begin
              if (req_q == '0 || req_q > aea_pkg::SIZE_LIMIT) begin
                st_q  <= aea_pkg::ST_INVALID;
                state <= S_DONE;
              end else begin
                asz_q <= ru_req[AW-1:0];
                phase <= PH_ALLOC;
                state <= S_RD_REQ;
              end
            end
            aea_pkg::OP_FREE: begin
              len_q <= free_cut;
              state <= S_PREP2;
            end
            default: begin
              st_q  <= aea_pkg::ST_INVALID;
              state <= S_DONE;
            end
          endcase
        end
        S_PREP2: begin
          if (len_q == '0) begin
            st_q  <= aea_pkg::ST_INVALID;
            state <= S_DONE;
          end else begin
            fend_q   <= off_q + len_q;
            has_prev <= 1'b0;
            has_next <= 1'b0;
            phase    <= PH_FPOS;
            state    <= S_RD_REQ;
          end
        end
        S_RD_REQ: begin
          if (j < count) begin
            state <= S_RD_LOAD;
          end else begin
            unique case (phase)
              PH_ALLOC: begin
                st_q  <= aea_pkg::ST_NO_FIT;
                state <= S_DONE;
              end
              PH_FPOS: state <= S_DEC;
              default: state <= S_FIN;
            endcase
          end
        end
        S_RD_LOAD: begin
          cur_s <= ext_rd.start;
          cur_z <= ext_rd.size;
          cur_e <= XW'(ext_rd.start) + XW'(ext_rd.size);
          cur_a <= ru_s;
          state <= S_CHK;
        end
        S_CHK: begin
          unique case (phase)
            PH_ALLOC: begin
              cur_end <= cur_a + XW'(asz_q);
              state   <= S_FIT;
            end
            PH_FPOS: begin
              if (cur_s < off_q) begin
                prev_s   <= cur_s;
                prev_e   <= cur_e[AW-1:0];
                prev_z   <= cur_z;
                has_prev <= 1'b1;
                j        <= j + CW'(1);
                state    <= S_RD_REQ;
              end else begin
                next_s   <= cur_s;
                next_e   <= cur_e[AW-1:0];
                next_z   <= cur_z;
                has_next <= 1'b1;
                state    <= S_DEC;
              end
            end
            default: begin
              if (cur_s <= me) begin
                if (cur_e[AW-1:0] > me) begin
                  me <= cur_e[AW-1:0];
                end
                removed <= removed + cur_z;
                k_q     <= k_q + CW'(1);
                j       <= j + CW'(1);
                state   <= S_RD_REQ;
              end else begin
                state <= S_FIN;
              end
            end
          endcase
        end
        S_FIT: begin
          if (cur_end > cur_e) begin
            j     <= j + CW'(1);
            state <= S_RD_REQ;
          end else if (fit_front && fit_back && count >= CW'(MAX_EXTENTS)) begin
            st_q  <= aea_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            boff_q      <= cur_a[AW-1:0];
            blen_q      <= asz_q;
            rid_q       <= next_region;
            next_region <= next_region + 64'd1;
            free_sum    <= free_sum - asz_q;
            w1_addr     <= j[IW-1:0];
            w2_addr     <= IW'(j + CW'(1));
            w2_data     <= {cur_end[AW-1:0], cur_e[AW-1:0] - cur_end[AW-1:0]};
            if (fit_front && fit_back) begin
              // front and back remnants: open a slot after this entry
              w1_en   <= 1'b1;
              w2_en   <= 1'b1;
              w1_data <= {cur_s, cur_a[AW-1:0] - cur_s};
              count   <= count + CW'(1);
              sh_up   <= 1'b1;
              sh_src  <= count - CW'(1);
              sh_stop <= j + CW'(1);
              state   <= (count >= j + CW'(2)) ? S_SH_RD : S_WR1;
            end else if (fit_front) begin
              w1_en   <= 1'b1;
              w1_data <= {cur_s, cur_a[AW-1:0] - cur_s};
              state   <= S_WR1;
            end else if (fit_back) begin
              w1_en   <= 1'b1;
              w1_data <= {cur_end[AW-1:0], cur_e[AW-1:0] - cur_end[AW-1:0]};
              state   <= S_WR1;
            end else begin
              // exact fit: erase the entry
              count   <= count - CW'(1);
              sh_up   <= 1'b0;
              sh_k    <= CW'(1);
              sh_src  <= j + CW'(1);
              sh_stop <= count - CW'(1);
              state   <= (count >= j + CW'(2)) ? S_SH_RD : S_WR1;
            end
          end
        end
        S_DEC: begin
          k_q <= '0;
          if (has_prev && prev_e >= off_q) begin
            p_q     <= IW'(j - CW'(1));
            ms      <= prev_s;
            me      <= (fend_q > prev_e) ? fend_q : prev_e;
            removed <= prev_z;
            phase   <= PH_FABS;
            state   <= S_RD_REQ;
          end else if (has_next && fend_q >= next_s) begin
            p_q     <= j[IW-1:0];
            ms      <= off_q;
            me      <= (fend_q > next_e) ? fend_q : next_e;
            removed <= next_z;
            j       <= j + CW'(1);
            phase   <= PH_FABS;
            state   <= S_RD_REQ;
          end else if (count >= CW'(MAX_EXTENTS)) begin
            st_q  <= aea_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            // isolated extent: insert at the sorted position
            w1_en    <= 1'b1;
            w1_addr  <= j[IW-1:0];
            w1_data  <= {off_q, len_q};
            count    <= count + CW'(1);
            free_sum <= free_sum + len_q;
            sh_up    <= 1'b1;
            sh_src   <= count - CW'(1);
            sh_stop  <= j;
            state    <= (count > j) ? S_SH_RD : S_WR1;
          end
        end
        S_FIN: begin
          free_sum <= free_sum - removed;
          len_m    <= me - ms;
          state    <= S_FIN2;
        end
        S_FIN2: begin
          free_sum <= free_sum + len_m;
          w1_en    <= 1'b1;
          w1_addr  <= p_q;
          w1_data  <= {ms, len_m};
          count    <= count - k_q;
          sh_up    <= 1'b0;
          sh_k     <= k_q;
          sh_src   <= fin_lo;
          sh_stop  <= count - CW'(1);
          state    <= (k_q != '0 && fin_lo < count) ? S_SH_RD : S_WR1;
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if (sh_src == sh_stop) begin
            state <= S_WR1;
          end else begin
            sh_src <= sh_up ? (sh_src - CW'(1)) : (sh_src + CW'(1));
            state  <= S_SH_RD;
          end
        end
        S_WR1: state <= S_WR2;
        S_WR2: state <= S_DONE;
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid    <= 1'b1;
            status       <= st_q;
            block_offset <= boff_q;
            block_length <= blen_q;
            region_id    <= rid_q;
            free_total   <= free_sum;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sim/extent_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_list_checker
// Watches the request, result and register ports of the extent allocator,
// keeps its own free-extent list and compares every result field by field.
// ----------------------------------------------------------------------------
module extent_list_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [aea_pkg::ADDR_W-1:0] cfg_data,
  input  logic                       req_valid,
  input  logic                       req_stall,
  input  logic [1:0]                 operation,
  input  logic [aea_pkg::ADDR_W-1:0] request_size,
  input  logic [aea_pkg::ADDR_W-1:0] free_offset,
  input  logic [aea_pkg::ADDR_W-1:0] free_length,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  logic [1:0]                 status,
  input  logic [aea_pkg::ADDR_W-1:0] block_offset,
  input  logic [aea_pkg::ADDR_W-1:0] block_length,
  input  logic [63:0]                region_id,
  input  logic [aea_pkg::ADDR_W-1:0] free_total,
  output int                         errors,
  output int                         pending,
  output int                         checked
);

  localparam int          AW        = aea_pkg::ADDR_W;
  localparam logic [63:0] ADDR_MASK = (64'd1 << AW) - 64'd1;
  localparam logic [63:0] SIZE_CAP  = 64'd1 << 48;

  typedef struct packed {
    logic [1:0]    st;
    logic [AW-1:0] off;
    logic [AW-1:0] len;
    logic [63:0]   rid;
    logic [AW-1:0] total;
  } alloc_reply_t;

  logic [4:0]  align_exp;
  logic [63:0] base_reg, size_reg;
  logic [63:0] ext_start [aea_pkg::MAX_EXTENTS];
  logic [63:0] ext_size  [aea_pkg::MAX_EXTENTS];
  int          ext_cnt;
  logic [63:0] region_seq;
  logic [63:0] free_bytes;
  int          err_cnt = 0;
  int          chk_cnt = 0;

  alloc_reply_t awaited_replies[$];

  function automatic logic [63:0] align_up(logic [63:0] v);
    logic [63:0] m;
    m = (64'd1 << align_exp) - 64'd1;
    return (v + m) & ~m;
  endfunction

  function automatic void erase_at(int idx);
    for (int j = idx; j + 1 < ext_cnt; j++) begin
      ext_start[j] = ext_start[j+1];
      ext_size[j]  = ext_size[j+1];
    end
    ext_cnt--;
  endfunction

  function automatic void insert_at(int idx);
    for (int j = ext_cnt; j > idx; j--) begin
      ext_start[j] = ext_start[j-1];
      ext_size[j]  = ext_size[j-1];
    end
    ext_cnt++;
  endfunction

  function automatic void merge_following(int p);
    logic [63:0] e, ne;
    while (p + 1 < ext_cnt) begin
      e = ext_start[p] + ext_size[p];
      if (e < ext_start[p+1]) break;
      ne = ext_start[p+1] + ext_size[p+1];
      if (ne > e) e = ne;
      ext_size[p] = e - ext_start[p];
      erase_at(p + 1);
    end
  endfunction

  function automatic logic [1:0] take_block(logic [63:0] req, output alloc_reply_t r);
    logic [63:0] asz, s, e, a, be;
    logic        front, back;
    r = '0;
    if (req == 0 || req > SIZE_CAP) return aea_pkg::ST_INVALID;
    asz = align_up(req);
    for (int i = 0; i < ext_cnt; i++) begin
      s  = ext_start[i];
      e  = s + ext_size[i];
      a  = align_up(s);
      be = a + asz;
      if (be > e) continue;
      front = a > s;
      back  = be < e;
      if (front && back) begin
        // split leaves two remnants, needs a spare slot
        if (ext_cnt >= aea_pkg::MAX_EXTENTS) return aea_pkg::ST_FULL;
        insert_at(i + 1);
        ext_size[i]    = a - s;
        ext_start[i+1] = be;
        ext_size[i+1]  = e - be;
      end else if (front) begin
        ext_size[i] = a - s;
      end else if (back) begin
        ext_start[i] = be;
        ext_size[i]  = e - be;
      end else begin
        erase_at(i);
      end
      r.off = a[AW-1:0];
      r.len = asz[AW-1:0];
      r.rid = region_seq;
      region_seq++;
      return aea_pkg::ST_OK;
    end
    return aea_pkg::ST_NO_FIT;
  endfunction

  function automatic logic [1:0] return_block(logic [63:0] off, logic [63:0] len);
    int          pos, p;
    logic [63:0] fend, pend, nend;
    pos = 0;
    if (len > ADDR_MASK - off) len = ADDR_MASK - off;
    if (len == 0) return aea_pkg::ST_INVALID;
    fend = off + len;
    while (pos < ext_cnt && ext_start[pos] < off) pos++;
    if (pos > 0 && ext_start[pos-1] + ext_size[pos-1] >= off) begin
      pend = ext_start[pos-1] + ext_size[pos-1];
      p = pos - 1;
      if (fend > pend) pend = fend;
      ext_size[p] = pend - ext_start[p];
    end else if (pos < ext_cnt && fend >= ext_start[pos]) begin
      nend = ext_start[pos] + ext_size[pos];
      p = pos;
      if (fend > nend) nend = fend;
      ext_start[p] = off;
      ext_size[p]  = nend - off;
    end else begin
      if (ext_cnt >= aea_pkg::MAX_EXTENTS) return aea_pkg::ST_FULL;
      insert_at(pos);
      p = pos;
      ext_start[p] = off;
      ext_size[p]  = len;
    end
    merge_following(p);
    return aea_pkg::ST_OK;
  endfunction

  function automatic alloc_reply_t allocate_or_free(logic [1:0] op, logic [63:0] rs,
                                                    logic [63:0] fo, logic [63:0] fl);
    alloc_reply_t r;
    logic [63:0]  len, sum;
    r = '0;
    sum = 0;
    case (op)
      aea_pkg::OP_INIT: begin
        len = size_reg;
        if (len > ADDR_MASK - base_reg) len = ADDR_MASK - base_reg;
        ext_cnt = 0;
        if (len != 0) begin
          ext_start[0] = base_reg;
          ext_size[0]  = len;
          ext_cnt = 1;
        end
        region_seq = 1;
      end
      aea_pkg::OP_ALLOC: r.st = take_block(rs, r);
      aea_pkg::OP_FREE:  r.st = return_block(fo, fl);
      default:           r.st = aea_pkg::ST_INVALID;
    endcase
    for (int i = 0; i < ext_cnt; i++) sum += ext_size[i];
    free_bytes = (sum > ADDR_MASK) ? ADDR_MASK : sum;
    r.total = free_bytes[AW-1:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  assign pending = awaited_replies.size();
  assign errors  = err_cnt;
  assign checked = chk_cnt;

  always @(posedge clk) begin
    alloc_reply_t want;
    if (rst) begin
      align_exp  <= aea_pkg::ALIGN_RESET;
      base_reg   <= '0;
      size_reg   <= '0;
      ext_cnt    = 0;
      region_seq = 64'd1;
      free_bytes = '0;
      awaited_replies.delete();
    end else begin
      if (res_valid && !res_stall) begin
        chk_cnt++;
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d",
                   $time, status);
          err_cnt++;
        end else begin
          want = awaited_replies.pop_front();
          compare_field("status", 64'(want.st), 64'(status));
          compare_field("block_offset", 64'(want.off), 64'(block_offset));
          compare_field("block_length", 64'(want.len), 64'(block_length));
          compare_field("region_id", want.rid, region_id);
          compare_field("free_total", 64'(want.total), 64'(free_total));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          aea_pkg::REG_ALIGN: align_exp <= cfg_data[4:0];
          aea_pkg::REG_BASE:  base_reg  <= 64'(cfg_data);
          aea_pkg::REG_SIZE:  size_reg  <= 64'(cfg_data);
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        awaited_replies.insert(awaited_replies.size(),
                               allocate_or_free(operation, 64'(request_size),
                                                64'(free_offset), 64'(free_length)));
    end
  end

endmodule

[sim/tb_aligned_extent_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aligned_extent_allocator
// Drives init, allocate, free and unused-operation requests into the extent allocator under
// several pool and alignment settings and idle/stall mixes; the checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_aligned_extent_allocator;

  localparam int          AW           = aea_pkg::ADDR_W;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [63:0] ADDR_TOP     = (64'd1 << AW) - 64'd1;
  localparam int          CYCLE_LIMIT  = 6_000_000;
  localparam int          RANDOM_ITEMS = 850;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = aea_pkg::REG_ALIGN;
  logic [AW-1:0] cfg_data = '0;
  logic          req_valid = 1'b0;
  logic          req_stall;
  logic [1:0]    operation = aea_pkg::OP_INIT;
  logic [AW-1:0] request_size = '0;
  logic [AW-1:0] free_offset = '0;
  logic [AW-1:0] free_length = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  logic [1:0]    status;
  logic [AW-1:0] block_offset;
  logic [AW-1:0] block_length;
  logic [63:0]   region_id;
  logic [AW-1:0] free_total;

  int errors, pending, checked;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int cycles = 0;
  int status_seen [4];
  logic [63:0] live_off[$];
  logic [63:0] live_len[$];

  aligned_extent_allocator dut (.*);

  extent_list_checker u_checker (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) res_stall <= ($urandom_range(0, 99) < stall_pct);

  // remember granted blocks so frees can hand real extents back
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      status_seen[status]++;
      if (status == aea_pkg::ST_OK && block_length != 0) begin
        live_off.insert(live_off.size(), 64'(block_offset));
        live_len.insert(live_len.size(), 64'(block_length));
      end
    end
  end

  function automatic logic [63:0] rand49();
    return {$urandom, $urandom} & ADDR_TOP;
  endfunction

  task automatic send(logic [1:0] op, logic [63:0] rs, logic [63:0] fo, logic [63:0] fl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    operation    <= op;
    request_size <= rs[AW-1:0];
    free_offset  <= fo[AW-1:0];
    free_length  <= fl[AW-1:0];
    if (op == aea_pkg::OP_INIT) begin
      live_off.delete();
      live_len.delete();
    end
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic quiesce();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [4:0] al, logic [63:0] base, logic [63:0] sz);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= aea_pkg::REG_ALIGN;
    cfg_data  <= AW'(al);
    @(posedge clk);
    cfg_index <= aea_pkg::REG_BASE;
    cfg_data  <= base[AW-1:0];
    @(posedge clk);
    cfg_index <= aea_pkg::REG_SIZE;
    cfg_data  <= sz[AW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic give_back_live();
    int          k;
    logic [63:0] o, l;
    k = $urandom_range(0, live_off.size() - 1);
    o = live_off[k];
    l = live_len[k];
    live_off.delete(k);
    live_len.delete(k);
    // now and then return a piece, or overshoot into neighbors
    case ($urandom_range(0, 9))
      0: l = l >> 1;
      1: l = l + $urandom_range(1, 4096);
      2: o = o + (l >> 2);
      default: ;
    endcase
    send(aea_pkg::OP_FREE, rand49(), o, l);
  endtask

  task automatic pool_episode(int n_ops);
    logic [4:0]  al;
    logic [63:0] base, sz, rs;
    int          pick;
    case ($urandom_range(0, 9))
      0:       al = 5'd30;
      1:       al = 5'($urandom_range(0, 30));
      default: al = 5'($urandom_range(0, 8));
    endcase
    base = ($urandom_range(0, 7) == 0) ? rand49() : 64'($urandom_range(0, 1 << 20));
    sz   = ($urandom_range(0, 9) == 0) ? rand49() : 64'($urandom_range(1 << 10, 1 << 22));
    if ($urandom_range(0, 19) == 0) sz = 0;
    set_config(al, base, sz);
    send(aea_pkg::OP_INIT, rand49(), rand49(), rand49());
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        rs = 64'($urandom_range(1, 1 + (sz >> 3 > 64'hFFFF_FFF0 ? 32'hFFFF_FFF0
                                                                 : 32'(sz >> 3))));
        send(aea_pkg::OP_ALLOC, rs, rand49(), rand49());
      end else if (pick < 80 && live_off.size() != 0) begin
        give_back_live();
      end else if (pick < 90) begin
        send(aea_pkg::OP_FREE, rand49(), base + $urandom_range(0, 32'(sz & 64'hFF_FFFF)),
             64'($urandom_range(0, 8192)));
      end else if (pick < 96) begin
        send(2'($urandom), rand49(), rand49(), rand49());
      end else begin
        send(aea_pkg::OP_INIT, rand49(), rand49(), rand49());
      end
    end
  endtask

  // fill the list to its limit with disjoint pieces, then hit the full cases
  task automatic scatter_episode();
    logic        down;
    int          k;
    down = 1'($urandom_range(0, 1));
    set_config(5'd3, 64'd0, 64'd0);
    send(aea_pkg::OP_INIT, rand49(), rand49(), rand49());
    for (int i = 0; i < aea_pkg::MAX_EXTENTS + 2; i++) begin
      k = down ? aea_pkg::MAX_EXTENTS + 1 - i : i;
      send(aea_pkg::OP_FREE, rand49(), 64'(k * 64 + 1), 64'd40);
    end
    send(aea_pkg::OP_ALLOC, 64'd8, rand49(), rand49());
    for (int i = 0; i < 6; i++) begin
      k = $urandom_range(0, aea_pkg::MAX_EXTENTS - 2);
      send(aea_pkg::OP_FREE, rand49(), 64'(k * 64 + 41), 64'($urandom_range(10, 30)));
      send(aea_pkg::OP_ALLOC, 64'($urandom_range(1, 60)), rand49(), rand49());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, empty list
    send(aea_pkg::OP_ALLOC, 64'd1, 64'd0, 64'd0);
    send(OP_UNUSED, ADDR_TOP, ADDR_TOP, ADDR_TOP);

    set_config(5'd12, 64'h1000, 64'd1 << 24);
    send(aea_pkg::OP_INIT, 64'd0, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd0, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, (64'd1 << 48) + 1, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, ADDR_TOP, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd1, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd5000, 64'd0, 64'd0);
    send(aea_pkg::OP_FREE, 64'd0, 64'h1000, 64'd4096);
    send(aea_pkg::OP_FREE, 64'd0, 64'h1000, 64'd0);
    send(aea_pkg::OP_FREE, 64'd0, 64'h1000, 64'd1 << 20);
    send(aea_pkg::OP_FREE, 64'd0, ADDR_TOP, ADDR_TOP);
    send(aea_pkg::OP_FREE, 64'd0, ADDR_TOP - 1, ADDR_TOP);
    send(aea_pkg::OP_ALLOC, 64'd1 << 48, 64'd0, 64'd0);

    set_config(5'd30, ADDR_TOP, ADDR_TOP);
    send(aea_pkg::OP_INIT, 64'd0, 64'd0, 64'd0);
    set_config(5'd30, 64'd0, ADDR_TOP);
    send(aea_pkg::OP_INIT, 64'd0, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd1 << 48, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd1, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd1 << 48, 64'd0, 64'd0);

    set_config(5'd0, 64'd7, 64'd100);
    send(aea_pkg::OP_INIT, 64'd0, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd3, 64'd0, 64'd0);
    send(aea_pkg::OP_ALLOC, 64'd97, 64'd0, 64'd0);
    send(aea_pkg::OP_FREE, 64'd0, 64'd7, 64'd3);
    send(aea_pkg::OP_FREE, 64'd0, 64'd20, 64'd5);

    for (int ph = 0; ph < 4; ph++) begin
      quiesce();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      while (sent < (ph + 1) * RANDOM_ITEMS / 4) begin
        if ($urandom_range(0, 5) == 0) scatter_episode();
        else pool_episode($urandom_range(30, 80));
      end
    end

    quiesce();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests, checked %0d results across four idle/stall mixes.",
             sent, checked);
    $display("Status counts: ok %0d, no fit %0d, invalid %0d, list full %0d.",
             status_seen[aea_pkg::ST_OK], status_seen[aea_pkg::ST_NO_FIT],
             status_seen[aea_pkg::ST_INVALID], status_seen[aea_pkg::ST_FULL]);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
